>>> rtl/acoc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and item types of the offset calibrator.
package acoc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_DIV   = 2'd2;

  localparam int CODE_W = 12;
  localparam int GAIN_W = 16;
  localparam int EDIV_W = 16;
  localparam int DIFF_W = CODE_W + 1;
  localparam int PROD_W = 28;
  localparam int OFF_W  = 28;
  localparam int CUR_W  = 29;

  localparam logic [CODE_W-1:0]        ZERO_CODE_RESET = 12'd2252;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET      = -16'sd480;
  localparam logic [EDIV_W-1:0]        ENC_DIV_RESET   = 16'd204;

  localparam int SAMPLES_DEFAULT = 1024;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_a;
    logic signed [DIFF_W-1:0] diff_b;
    logic signed [DIFF_W-1:0] diff_c;
    logic                     restart;
    logic                     strobe;
  } front_item_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] current_a;
    logic signed [CUR_W-1:0] current_b;
    logic signed [CUR_W-1:0] current_c;
    logic                    calibrated;
    logic                    encoder_strobe;
  } result_t;

endpackage

>>> rtl/acoc_fifo.sv
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty sides.
module acoc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  // DEPTH is a power of two so that the pointers wrap on their own.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/acoc_front.sv
`timescale 1ns / 1ps
// Front end: takes raw codes, removes the zero code and runs the encoder divider.
module acoc_front
  import acoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [CODE_W-1:0] code_a,
  input  logic [CODE_W-1:0] code_b,
  input  logic [CODE_W-1:0] code_c,
  input  logic              restart,
  input  logic [CODE_W-1:0] zero_code,
  input  logic [EDIV_W-1:0] encoder_divide,
  input  logic              item_full,
  output logic              item_push,
  output front_item_t       item
);

  logic [EDIV_W-1:0] div_count;
  logic [EDIV_W-1:0] div_inc;
  logic              strobe;

  assign item_push = push && !item_full;
  assign div_inc   = div_count + 1'b1;
  assign strobe    = (div_inc == encoder_divide);

  always_comb begin
    item.diff_a  = $signed({1'b0, code_a}) - $signed({1'b0, zero_code});
    item.diff_b  = $signed({1'b0, code_b}) - $signed({1'b0, zero_code});
    item.diff_c  = $signed({1'b0, code_c}) - $signed({1'b0, zero_code});
    item.restart = restart;
    item.strobe  = strobe;
  end

  // The divider advances on every transfer and is not touched by a restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (item_push) begin
      div_count <= strobe ? '0 : div_inc;
    end
  end

endmodule

>>> rtl/acoc_div.sv
`timescale 1ns / 1ps
// Signed division of a channel sum by the sample count through a constant reciprocal.
module acoc_div #(
  parameter int SAMPLES = 1024,
  parameter int SUM_W   = 39,
  parameter int OFF_W   = 28
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  output logic                    busy,
  output logic                    done,
  output logic signed [OFF_W-1:0] quotient
);

  localparam int MAG_W  = SUM_W - 1;
  localparam int DIG_W  = 16;
  localparam int NDIG   = (MAG_W + DIG_W - 1) / DIG_W;
  localparam int XS_W   = NDIG * DIG_W;
  localparam int LOG_D  = $clog2(SAMPLES);
  localparam int SH     = MAG_W + LOG_D;
  localparam int RW     = MAG_W + 2;
  localparam int PART_W = RW + DIG_W;
  localparam int ACC_W  = XS_W + RW;
  localparam int STEP_W = $clog2(NDIG + 1);
  // With this reciprocal, floor(x * RECIP / 2^SH) equals floor(x / SAMPLES) for every
  // magnitude x below 2^MAG_W.
  localparam logic [63:0]   RECIP_FULL = ((64'd1 << SH) / 64'(SAMPLES)) + 64'd1;
  localparam logic [RW-1:0] RECIP      = RECIP_FULL[RW-1:0];

  logic [STEP_W-1:0] step;
  logic              neg;
  logic [MAG_W-1:0]  abs_val;
  logic [XS_W-1:0]   xs;
  logic [ACC_W-1:0]  acc;
  logic [PART_W-1:0] part;
  logic [OFF_W-1:0]  mag;

  assign abs_val  = dividend[SUM_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
  assign part     = PART_W'(RECIP) * PART_W'(xs[XS_W-1 -: DIG_W]);
  assign mag      = acc[SH +: OFF_W];
  // Dividing the magnitude and restoring the sign truncates toward zero.
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[SUM_W-1];
      xs   <= XS_W'(abs_val);
      acc  <= '0;
      step <= '0;
    end else if (busy) begin
      // Digits go in most significant first, so the partial product moves up one digit.
      acc  <= (acc << DIG_W) + ACC_W'(part);
      xs   <= xs << DIG_W;
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(NDIG - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/acoc_back.sv
`timescale 1ns / 1ps
// Back end: gain multiply, offset removal, calibration sums and offset update.
module acoc_back
  import acoc_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [GAIN_W-1:0] gain,
  input  front_item_t              item,
  input  logic                     item_empty,
  output logic                     item_pop,
  input  logic                     res_full,
  output logic                     res_push,
  output result_t                  res
);

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int SUM_W = PROD_W + CNT_W;
  localparam int MUL_W = DIFF_W + GAIN_W;

  // Multiply stage.
  logic                     m_valid;
  logic signed [PROD_W-1:0] m_prod [3];
  logic                     m_restart;
  logic                     m_strobe;
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [MUL_W-1:0]  mul [3];
  logic                     m_load;

  // Calibration state.
  logic [CNT_W-1:0]         count;
  logic                     calib_done;
  logic signed [SUM_W-1:0]  sums [3];
  logic signed [OFF_W-1:0]  offsets [3];

  logic [CNT_W-1:0]         cnt_eff;
  logic [CNT_W-1:0]         count_next;
  logic                     done_eff;
  logic                     done_next;
  logic signed [SUM_W-1:0]  sums_eff [3];
  logic signed [SUM_W-1:0]  sums_next [3];
  logic signed [OFF_W-1:0]  off_eff [3];
  logic signed [CUR_W-1:0]  cur [3];
  logic                     accum;
  logic                     complete;
  logic                     a_go;

  logic [2:0]               lane_busy;
  logic [2:0]               lane_done;
  logic signed [OFF_W-1:0]  quot [3];

  always_comb begin
    diff[0] = item.diff_a;
    diff[1] = item.diff_b;
    diff[2] = item.diff_c;
    for (int i = 0; i < 3; i++) begin
      mul[i] = diff[i] * gain;
    end
  end

  // The accumulate stage waits while new offsets are being divided out.
  assign a_go     = m_valid && !res_full && !(|lane_busy) && !(|lane_done);
  assign m_load   = !m_valid || a_go;
  assign item_pop = m_load && !item_empty;
  assign res_push = a_go;

  always_ff @(posedge clk) begin
    if (item_pop) begin
      for (int i = 0; i < 3; i++) begin
        m_prod[i] <= mul[i][PROD_W-1:0];
      end
      m_restart <= item.restart;
      m_strobe  <= item.strobe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= item_pop || (m_valid && !a_go);
    end
  end

  always_comb begin
    cnt_eff  = m_restart ? '0 : count;
    done_eff = m_restart ? 1'b0 : calib_done;
    accum    = (cnt_eff < CNT_W'(SAMPLES));
    complete = (cnt_eff == CNT_W'(SAMPLES - 1));
    count_next = accum ? cnt_eff + 1'b1 : cnt_eff;
    done_next  = done_eff || complete;
    for (int i = 0; i < 3; i++) begin
      off_eff[i]  = m_restart ? '0 : offsets[i];
      sums_eff[i] = m_restart ? '0 : sums[i];
      cur[i] = {{(CUR_W - PROD_W){m_prod[i][PROD_W-1]}}, m_prod[i]}
             - {{(CUR_W - OFF_W){off_eff[i][OFF_W-1]}}, off_eff[i]};
      // Offsets are zero while summing, so the product is the current here.
      sums_next[i] = accum
                   ? sums_eff[i] + {{(SUM_W - PROD_W){m_prod[i][PROD_W-1]}}, m_prod[i]}
                   : sums_eff[i];
    end
  end

  always_comb begin
    res.current_a      = cur[0];
    res.current_b      = cur[1];
    res.current_c      = cur[2];
    res.calibrated     = done_next;
    res.encoder_strobe = m_strobe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      calib_done <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sums[i]    <= '0;
        offsets[i] <= '0;
      end
    end else if (a_go) begin
      count      <= count_next;
      calib_done <= done_next;
      for (int i = 0; i < 3; i++) begin
        sums[i]    <= sums_next[i];
        offsets[i] <= off_eff[i];
      end
    end else if (|lane_done) begin
      for (int i = 0; i < 3; i++) begin
        offsets[i] <= quot[i];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    acoc_div #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W),
      .OFF_W   (OFF_W)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (a_go && complete),
      .dividend (sums_next[g]),
      .busy     (lane_busy[g]),
      .done     (lane_done[g]),
      .quotient (quot[g])
    );
  end

endmodule

>>> rtl/adc_current_offset_calibrator_unit.sv
`timescale 1ns / 1ps
// Phase current offset calibrator: zero code removal, Q16 gain and averaged offsets.
// Each item is registered in the item queue, the multiply stage and the result queue.
// Throughput is one item per cycle unless the result queue is full; the item that
// completes calibration stalls the back end while the sum is divided by 16-bit digits.
// Synchronous active-high reset restores register defaults and clears all calibration.
module adc_current_offset_calibrator_unit
  import acoc_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic [CODE_W-1:0]           code_a,
  input  logic [CODE_W-1:0]           code_b,
  input  logic [CODE_W-1:0]           code_c,
  input  logic                        restart,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [CUR_W-1:0]     current_a,
  output logic signed [CUR_W-1:0]     current_b,
  output logic signed [CUR_W-1:0]     current_c,
  output logic                        calibrated,
  output logic                        encoder_strobe
);

  localparam int ITEM_W = $bits(front_item_t);
  localparam int RES_W  = $bits(result_t);

  logic [CODE_W-1:0]        zero_code;
  logic signed [GAIN_W-1:0] gain_q16;
  logic [EDIV_W-1:0]        encoder_divide;

  front_item_t f_item;
  front_item_t b_item;
  logic        f_push;
  logic        b_pop;
  logic        b_empty;
  result_t     b_res;
  result_t     o_res;
  logic        r_push;
  logic        r_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_code      <= ZERO_CODE_RESET;
      gain_q16       <= GAIN_RESET;
      encoder_divide <= ENC_DIV_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZERO_CODE: zero_code      <= cfg_data[CODE_W-1:0];
        REG_GAIN:      gain_q16       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_ENC_DIV:   encoder_divide <= cfg_data[EDIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  acoc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .code_a         (code_a),
    .code_b         (code_b),
    .code_c         (code_c),
    .restart        (restart),
    .zero_code      (zero_code),
    .encoder_divide (encoder_divide),
    .item_full      (full),
    .item_push      (f_push),
    .item           (f_item)
  );

  acoc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_item),
    .full  (full),
    .pop   (b_pop),
    .rdata (b_item),
    .empty (b_empty)
  );

  acoc_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .gain       (gain_q16),
    .item       (b_item),
    .item_empty (b_empty),
    .item_pop   (b_pop),
    .res_full   (r_full),
    .res_push   (r_push),
    .res        (b_res)
  );

  acoc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (b_res),
    .full  (r_full),
    .pop   (pop),
    .rdata (o_res),
    .empty (empty)
  );

  assign current_a      = o_res.current_a;
  assign current_b      = o_res.current_b;
  assign current_c      = o_res.current_c;
  assign calibrated     = o_res.calibrated;
  assign encoder_strobe = o_res.encoder_strobe;

endmodule
